// ===== sv/fbf_pkg.sv =====
// ----------------------------------------------------------------------------
// fbf_pkg: shared types and constants of the frontier bellman-ford block
// Sizes of the edge, row and vertex stores, item codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbf_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 8192;
  localparam int WEIGHT_BITS  = 16;

  localparam int VA_W  = $clog2(MAX_VERTICES);      // vertex index
  localparam int VC_W  = $clog2(MAX_VERTICES + 1);  // vertex count
  localparam int EA_W  = $clog2(MAX_EDGES);         // edge index
  localparam int EC_W  = $clog2(MAX_EDGES + 1);     // edge count
  localparam int RA_W  = $clog2(MAX_VERTICES + 1);  // row start index
  localparam int DIST_W = 32;

  localparam logic signed [DIST_W-1:0] DIST_INF = 32'sd1000000;

  localparam logic [VC_W-1:0] VC_RESET  = VC_W'(MAX_VERTICES);

  // register index carried by paddr[2]
  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_SOURCE_VERTEX = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_PASS     = 2'd0,
    MODE_CHK_NEXT = 2'd1,
    MODE_CHK_ALL  = 2'd2
  } mode_t;

  typedef struct packed {
    logic  capture;
    logic  ld_check;
    logic  ld_fill;
    logic  ld_commit;
    logic  rd_issue;
    logic  out_read;
    logic  out_sum;
    logic  init_step;
    logic  src_set;
    logic  pass_start;
    logic  clr_step;
    logic  u_zero;
    logic  v_lo;
    logic  v_hi;
    logic  e_dist;
    logic  e_eval;
    logic  v_next;
    logic  sel_flip;
    mode_t mode;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic fill_more;
    logic u_last;
    logic nv_gt1;
    logic go_edges;
    logic edge_last;
    logic relax_hit;
    logic improved;
    logic last_pass;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/fbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbf_ctrl: sequencer of the frontier bellman-ford block
// Walks edge loads, vertex reads and runs (init sweep, passes, cycle checks)
// and issues one command group a cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fbf_ctrl
  import fbf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] kind,
  output logic            in_stall,
  output cmd_t            cmd,
  input  wire stat_t      stat
);

  typedef enum logic [18:0] {
    S_IDLE       = 19'h00001,
    S_LD_CHECK   = 19'h00002,
    S_LD_FILL    = 19'h00004,
    S_RD_ISSUE   = 19'h00008,
    S_RD_WAIT    = 19'h00010,
    S_INIT       = 19'h00020,
    S_SRC        = 19'h00040,
    S_PASS_START = 19'h00080,
    S_CLR        = 19'h00100,
    S_V_ISSUE    = 19'h00200,
    S_V_LO       = 19'h00400,
    S_V_HI       = 19'h00800,
    S_E_ISSUE    = 19'h01000,
    S_E_DIST     = 19'h02000,
    S_E_EVAL     = 19'h04000,
    S_V_NEXT     = 19'h08000,
    S_PASS_END   = 19'h10000,
    S_FIN        = 19'h20000,
    S_DONE       = 19'h40000
  } state_t;

  state_t state, state_next;
  mode_t  mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_PASS;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mode   = mode;
    state_next = state;
    mode_next  = mode;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (kind)
            KIND_LOAD: state_next = S_LD_CHECK;
            KIND_RUN: begin
              state_next = S_INIT;
              mode_next  = MODE_PASS;
            end
            KIND_READ: state_next = S_RD_ISSUE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_LD_CHECK: begin
        cmd.ld_check = 1'b1;
        state_next   = stat.drop ? S_IDLE : S_LD_FILL;
      end
      S_LD_FILL: begin
        if (stat.fill_more) begin
          cmd.ld_fill = 1'b1;
        end else begin
          cmd.ld_commit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        // the registered read data is not held, so reissue the read while stalled
        if (stat.out_free) begin
          cmd.out_read = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_RD_ISSUE;
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.u_last) state_next = S_SRC;
      end
      S_SRC: begin
        cmd.src_set = 1'b1;
        state_next  = stat.nv_gt1 ? S_PASS_START : S_FIN;
      end
      S_PASS_START: begin
        cmd.pass_start = 1'b1;
        state_next     = S_CLR;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.u_last) state_next = S_V_ISSUE;
      end
      S_V_ISSUE: state_next = S_V_LO;
      S_V_LO: begin
        cmd.v_lo   = 1'b1;
        state_next = S_V_HI;
      end
      S_V_HI: begin
        cmd.v_hi   = 1'b1;
        state_next = stat.go_edges ? S_E_ISSUE : S_V_NEXT;
      end
      S_E_ISSUE: state_next = S_E_DIST;
      S_E_DIST: begin
        cmd.e_dist = 1'b1;
        state_next = S_E_EVAL;
      end
      S_E_EVAL: begin
        cmd.e_eval = 1'b1;
        priority if (mode != MODE_PASS && stat.relax_hit) state_next = S_DONE;
        else if (stat.edge_last) state_next = S_V_NEXT;
        else state_next = S_E_ISSUE;
      end
      S_V_NEXT: begin
        priority if (!stat.u_last) begin
          cmd.v_next = 1'b1;
          state_next = S_V_ISSUE;
        end else if (mode == MODE_PASS) begin
          state_next = S_PASS_END;
        end else if (mode == MODE_CHK_NEXT) begin
          state_next = S_FIN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PASS_END: begin
        priority if (stat.improved && stat.last_pass) begin
          cmd.u_zero = 1'b1;
          mode_next  = MODE_CHK_NEXT;
          state_next = S_V_ISSUE;
        end else if (!stat.improved) begin
          state_next = S_FIN;
        end else begin
          cmd.sel_flip = 1'b1;
          state_next   = S_PASS_START;
        end
      end
      S_FIN: begin
        if (stat.last_pass) begin
          cmd.u_zero = 1'b1;
          mode_next  = MODE_CHK_ALL;
          state_next = S_V_ISSUE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_sum = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/fbf_dpath.sv =====
// ----------------------------------------------------------------------------
// fbf_dpath: stores and arithmetic of the frontier bellman-ford block
// Edge, row start, distance, predecessor and frontier memories, the
// relaxation adder and compares, the run counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbf_dpath
  import fbf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cmd_t                          cmd,
  output stat_t                              stat,
  input  wire logic [VC_W-1:0]               vertex_count,
  input  wire logic [VA_W-1:0]               source_vertex,
  input  wire logic [VA_W-1:0]               from_vertex,
  input  wire logic [VA_W-1:0]               to_vertex,
  input  wire logic signed [WEIGHT_BITS-1:0] weight,
  input  wire logic [VA_W-1:0]               read_vertex,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               result_kind,
  output logic                               negative_cycle,
  output logic [9:0]                         passes_done,
  output logic                               edges_dropped,
  output logic [VA_W-1:0]                    vertex,
  output logic signed [DIST_W-1:0]           distance,
  output logic                               reachable,
  output logic                               has_predecessor,
  output logic [VA_W-1:0]                    predecessor
);

  localparam int CAND_W = DIST_W + 2;
  localparam int EW_W   = VA_W + WEIGHT_BITS;
  localparam logic signed [CAND_W-1:0] CAND_INF = CAND_W'(DIST_INF);
  localparam logic signed [CAND_W-1:0] CAND_MIN = -(CAND_W'(1) <<< (DIST_W - 1));

  // memories
  logic [EW_W-1:0]          edge_mem [MAX_EDGES];
  logic [EC_W-1:0]          row_mem  [MAX_VERTICES + 1];
  logic [DIST_W-1:0]        dist_mem [MAX_VERTICES];
  logic [VA_W:0]            pred_mem [MAX_VERTICES];
  logic                     fa_mem   [MAX_VERTICES];
  logic                     fb_mem   [MAX_VERTICES];

  logic [EW_W-1:0]          edge_rdata;
  logic [EC_W-1:0]          row_rdata;
  logic [DIST_W-1:0]        dist_rdata;
  logic [VA_W:0]            pred_rdata;
  logic                     fa_q, fb_q;

  // control registers
  logic [EC_W-1:0]          edge_count;
  logic [VA_W-1:0]          last_source;
  logic                     flag_drop, flag_cycle;

  // item and run registers
  logic [VA_W-1:0]          lfrom, lto, rv;
  logic [WEIGHT_BITS-1:0]   lw;
  logic [RA_W-1:0]          fill;
  logic [VA_W-1:0]          u;
  logic [9:0]               passes;
  logic                     improved, cycle, sel, act;
  logic signed [DIST_W-1:0] du;
  logic [EC_W-1:0]          j, hi;
  logic [VA_W-1:0]          ev;
  logic signed [WEIGHT_BITS-1:0] ew;

  logic [VC_W-1:0]          nv, nv_m1;
  logic                     src_ok, rd_ok;
  logic [EC_W-1:0]          row_lo, hi_val, j_inc;
  logic signed [CAND_W-1:0] cand, dv_ext;
  logic                     in_graph, over, under, better, upd, relax;
  logic                     fr_sel_bit;

  // memory ports
  logic [VA_W-1:0]          dist_raddr, dist_waddr, pred_waddr;
  logic                     dist_we, pred_we;
  logic [DIST_W-1:0]        dist_wdata;
  logic [VA_W:0]            pred_wdata;
  logic [RA_W-1:0]          row_raddr;
  logic                     fa_we, fb_we, fa_wdata, fb_wdata;
  logic [VA_W-1:0]          fa_waddr, fb_waddr;
  logic                     nx_we, nx_wdata;
  logic [VA_W-1:0]          nx_waddr;
  logic                     out_free;

  // effective vertex count
  always_comb begin
    priority if (vertex_count == '0) nv = VC_W'(1);
    else if (vertex_count > VC_W'(MAX_VERTICES)) nv = VC_W'(MAX_VERTICES);
    else nv = vertex_count;
  end
  assign nv_m1  = nv - VC_W'(1);
  assign src_ok = {1'b0, source_vertex} < nv;
  assign rd_ok  = {1'b0, rv} < nv;

  assign row_lo = (edge_count != '0 && u <= last_source) ? row_rdata : edge_count;
  assign hi_val = (u < last_source) ? row_rdata : edge_count;
  assign j_inc  = j + EC_W'(1);

  // relaxation arithmetic
  assign cand     = {{2{du[DIST_W-1]}}, du} +
                    {{(CAND_W - WEIGHT_BITS){ew[WEIGHT_BITS-1]}}, ew};
  assign dv_ext   = {{2{dist_rdata[DIST_W-1]}}, dist_rdata};
  assign in_graph = {1'b0, ev} < nv;
  assign over     = cand > CAND_INF;
  assign under    = cand < CAND_MIN;
  assign better   = cand < dv_ext;
  assign relax    = in_graph && !over && better;
  assign upd      = cmd.e_eval && (cmd.mode == MODE_PASS) && relax && !under;

  always_comb begin
    unique case (cmd.mode)
      MODE_PASS:     fr_sel_bit = sel ? fb_q : fa_q;
      MODE_CHK_NEXT: fr_sel_bit = sel ? fa_q : fb_q;
      default:       fr_sel_bit = 1'b1;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.drop      = (edge_count == EC_W'(MAX_EDGES)) ||
                     (edge_count != '0 && lfrom < last_source);
    stat.fill_more = fill <= {1'b0, lfrom};
    stat.u_last    = {1'b0, u} == nv_m1;
    stat.nv_gt1    = nv > VC_W'(1);
    stat.go_edges  = act && (j < hi_val);
    stat.edge_last = j_inc == hi;
    stat.relax_hit = relax;
    stat.improved  = improved;
    stat.last_pass = ({1'b0, passes} + VC_W'(1)) == nv;
    stat.out_free  = out_free;
  end

  // read address selection
  always_comb begin
    priority if (cmd.rd_issue) dist_raddr = rv;
    else if (cmd.e_dist) dist_raddr = edge_rdata[EW_W-1 -: VA_W];
    else dist_raddr = u;
  end
  assign row_raddr = cmd.v_lo ? ({1'b0, u} + RA_W'(1)) : {1'b0, u};

  // distance and predecessor writes
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = u;
    dist_wdata = DIST_INF;
    pred_we    = 1'b0;
    pred_waddr = u;
    pred_wdata = '0;
    priority if (cmd.init_step) begin
      dist_we = 1'b1;
      pred_we = 1'b1;
    end else if (cmd.src_set && src_ok) begin
      dist_we    = 1'b1;
      dist_waddr = source_vertex;
      dist_wdata = '0;
    end else if (upd) begin
      dist_we    = 1'b1;
      dist_waddr = ev;
      dist_wdata = cand[DIST_W-1:0];
      pred_we    = 1'b1;
      pred_waddr = ev;
      pred_wdata = {1'b1, u};
    end
  end

  // frontier writes; the next frontier is fa when sel is set
  assign nx_we    = cmd.clr_step || upd;
  assign nx_waddr = cmd.clr_step ? u : ev;
  assign nx_wdata = !cmd.clr_step;

  always_comb begin
    fa_we    = 1'b0;
    fa_waddr = u;
    fa_wdata = 1'b0;
    fb_we    = 1'b0;
    fb_waddr = u;
    fb_wdata = 1'b0;
    priority if (cmd.init_step) begin
      fa_we = 1'b1;
      fb_we = 1'b1;
    end else if (cmd.src_set) begin
      fa_we    = src_ok;
      fa_waddr = source_vertex;
      fa_wdata = 1'b1;
    end else if (sel) begin
      fa_we    = nx_we;
      fa_waddr = nx_waddr;
      fa_wdata = nx_wdata;
    end else begin
      fb_we    = nx_we;
      fb_waddr = nx_waddr;
      fb_wdata = nx_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_commit) edge_mem[edge_count[EA_W-1:0]] <= {lto, lw};
    edge_rdata <= edge_mem[j[EA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_fill) row_mem[fill] <= edge_count;
    row_rdata <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rdata <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_waddr] <= pred_wdata;
    pred_rdata <= pred_mem[rv];
  end

  always_ff @(posedge clk) begin
    if (fa_we) fa_mem[fa_waddr] <= fa_wdata;
    fa_q <= fa_mem[u];
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
    fb_q <= fb_mem[u];
  end

  // edge list bookkeeping and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count  <= '0;
      last_source <= '0;
      flag_drop   <= 1'b0;
      flag_cycle  <= 1'b0;
    end else begin
      if (cmd.ld_check && stat.drop) flag_drop <= 1'b1;
      if (cmd.ld_commit) begin
        edge_count  <= edge_count + EC_W'(1);
        last_source <= lfrom;
      end
      if (cmd.out_sum) flag_cycle <= cycle;
    end
  end

  // item and run registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lfrom    <= from_vertex;
      lto      <= to_vertex;
      lw       <= weight;
      rv       <= read_vertex;
      u        <= '0;
      passes   <= '0;
      improved <= 1'b1;
      cycle    <= 1'b0;
      sel      <= 1'b0;
    end
    if (cmd.ld_check) begin
      fill <= (edge_count == '0) ? '0 : ({1'b0, last_source} + RA_W'(1));
    end
    if (cmd.ld_fill) fill <= fill + RA_W'(1);
    if (cmd.init_step || cmd.clr_step) u <= stat.u_last ? '0 : u + VA_W'(1);
    if (cmd.pass_start) begin
      passes   <= passes + 10'd1;
      improved <= 1'b0;
      u        <= '0;
    end
    if (cmd.u_zero) u <= '0;
    if (cmd.v_next) u <= u + VA_W'(1);
    if (cmd.v_lo) begin
      du  <= dist_rdata;
      act <= fr_sel_bit && (dist_rdata != DIST_INF);
      j   <= row_lo;
    end
    if (cmd.v_hi) hi <= hi_val;
    if (cmd.e_dist) begin
      ev <= edge_rdata[EW_W-1 -: VA_W];
      ew <= edge_rdata[WEIGHT_BITS-1:0];
    end
    if (cmd.e_eval) begin
      j <= j_inc;
      if (upd) improved <= 1'b1;
      if (cmd.mode != MODE_PASS && relax) cycle <= 1'b1;
    end
    if (cmd.sel_flip) sel <= ~sel;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_read || cmd.out_sum) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_read) begin
      result_kind     <= 1'b1;
      negative_cycle  <= flag_cycle;
      passes_done     <= '0;
      edges_dropped   <= flag_drop;
      vertex          <= rv;
      distance        <= rd_ok ? dist_rdata : DIST_INF;
      reachable       <= rd_ok ? (dist_rdata != DIST_INF) : 1'b0;
      has_predecessor <= rd_ok && pred_rdata[VA_W];
      predecessor     <= (rd_ok && pred_rdata[VA_W]) ? pred_rdata[VA_W-1:0] : '0;
    end else if (cmd.out_sum) begin
      result_kind     <= 1'b0;
      negative_cycle  <= cycle;
      passes_done     <= passes;
      edges_dropped   <= flag_drop;
      vertex          <= '0;
      distance        <= '0;
      reachable       <= 1'b0;
      has_predecessor <= 1'b0;
      predecessor     <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/frontier_bellman_ford_top.sv =====
// ----------------------------------------------------------------------------
// frontier_bellman_ford_top: shortest paths with negative cycle detection
// Loads a csr edge list, runs frontier bellman-ford from a source vertex and
// answers per-vertex distance and predecessor reads.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | moves
//  in       | in_valid / in_stall         | kind, edge fields, read_vertex
//  out      | out_valid / out_stall       | run summary or vertex data word
//  config   | psel penable pwrite pready  | vertex_count, source_vertex
//
// edge load: capture, source order check, then one row start written per step,
// then the edge commit; a dropped edge ends after the check; read: issue, then
// wait, reissued while the output is stalled; run: an init sweep, then per pass
// a clear sweep, and per vertex and per visited edge the chained registered reads
// of the edge and distance memories; cycle checks take the same steps per vertex and edge
// one word is handled at a time; in_stall is low only when idle
// a result waits in the output register; out_stall holds it
// rst is synchronous; the stores hold no reset state
`default_nettype none

module frontier_bellman_ford_top
  import fbf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    kind,
  input  wire logic [VA_W-1:0]               from_vertex,
  input  wire logic [VA_W-1:0]               to_vertex,
  input  wire logic signed [WEIGHT_BITS-1:0] weight,
  input  wire logic [VA_W-1:0]               read_vertex,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               result_kind,
  output logic                               negative_cycle,
  output logic [9:0]                         passes_done,
  output logic                               edges_dropped,
  output logic [VA_W-1:0]                    vertex,
  output logic signed [DIST_W-1:0]           distance,
  output logic                               reachable,
  output logic                               has_predecessor,
  output logic [VA_W-1:0]                    predecessor,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [VC_W-1:0] vertex_count;
  logic [VA_W-1:0] source_vertex;
  logic            cfg_wr;
  cmd_t            cmd;
  stat_t           stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VC_RESET;
      source_vertex <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_VERTEX_COUNT) vertex_count <= pwdata[VC_W-1:0];
      else source_vertex <= pwdata[VA_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_SOURCE_VERTEX) prdata = {{(32 - VA_W){1'b0}}, source_vertex};
    else prdata = {{(32 - VC_W){1'b0}}, vertex_count};
  end

  fbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  fbf_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .vertex_count    (vertex_count),
    .source_vertex   (source_vertex),
    .from_vertex     (from_vertex),
    .to_vertex       (to_vertex),
    .weight          (weight),
    .read_vertex     (read_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .negative_cycle  (negative_cycle),
    .passes_done     (passes_done),
    .edges_dropped   (edges_dropped),
    .vertex          (vertex),
    .distance        (distance),
    .reachable       (reachable),
    .has_predecessor (has_predecessor),
    .predecessor     (predecessor)
  );

endmodule

`default_nettype wire

// ===== sim/frontier_bellman_ford_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frontier_bellman_ford_top_test: self-checking bench for the shortest path block
// Loads a csr edge list mostly in ascending source order, runs frontier bellman-ford
// under many vertex counts and sources and reads back distances. A behavioral
// shortest path calculator predicts every run summary and vertex data word;
// the monitor compares each output word field by field against it.
// ----------------------------------------------------------------------------
module frontier_bellman_ford_top_test;
  import fbf_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;
  localparam int DRAIN_WAIT  = 1100;  // a load may skip up to ~1k rows

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    kind = 2'd0;
  logic [VA_W-1:0]               from_vertex = '0;
  logic [VA_W-1:0]               to_vertex = '0;
  logic signed [WEIGHT_BITS-1:0] weight = '0;
  logic [VA_W-1:0]               read_vertex = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          result_kind;
  logic                          negative_cycle;
  logic [9:0]                    passes_done;
  logic                          edges_dropped;
  logic [VA_W-1:0]               vertex;
  logic signed [DIST_W-1:0]      distance;
  logic                          reachable;
  logic                          has_predecessor;
  logic [VA_W-1:0]               predecessor;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [2:0]                    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  frontier_bellman_ford_top u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic [1:0]                    kd;
    logic [VA_W-1:0]               src;
    logic [VA_W-1:0]               dst;
    logic signed [WEIGHT_BITS-1:0] wt;
    logic [VA_W-1:0]               rd;
  } word_t;

  typedef struct {
    logic                     rk;
    logic                     nc;
    logic [9:0]               passes;
    logic                     ed;
    logic [VA_W-1:0]          vtx;
    logic signed [DIST_W-1:0] span;
    logic                     reach;
    logic                     hp;
    logic [VA_W-1:0]          pred;
  } answer_t;

  word_t   word_q[$];
  answer_t answer_q[$];
  int      fails = 0;
  int      cycles = 0;
  bit      taken = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_cnt = 0;

  // ---------------- shortest path calculator ----------------
  logic [VA_W-1:0] e_to[MAX_EDGES];
  int              e_w[MAX_EDGES];
  int unsigned     row_st[MAX_VERTICES+1];
  int unsigned     n_edges = 0;
  int unsigned     last_src = 0;
  int              dist_m[MAX_VERTICES];
  bit              pv[MAX_VERTICES];
  logic [VA_W-1:0] pidx[MAX_VERTICES];
  bit              fnow[MAX_VERTICES];
  bit              fnext[MAX_VERTICES];
  bit              dropped = 0;
  bit              neg_cyc = 0;
  logic [10:0]     cfg_nv = 11'd1024;
  logic [9:0]      cfg_src = 10'd0;

  function automatic int unsigned live_nv();
    if (cfg_nv == 0) return 1;
    if (cfg_nv > MAX_VERTICES) return MAX_VERTICES;
    return cfg_nv;
  endfunction

  function automatic int unsigned row_lo(int unsigned u);
    if (n_edges > 0 && u <= last_src) return row_st[u];
    return n_edges;
  endfunction

  function automatic int unsigned row_hi(int unsigned u);
    if (u < last_src) return row_st[u+1];
    return n_edges;
  endfunction

  function automatic void store_edge(int unsigned f, logic [VA_W-1:0] t, int w);
    if (n_edges >= MAX_EDGES || (n_edges > 0 && f < last_src)) begin
      dropped = 1;
      return;
    end
    if (n_edges == 0) begin
      for (int unsigned v = 0; v <= f; v++) row_st[v] = 0;
    end else begin
      for (int unsigned v = last_src + 1; v <= f; v++) row_st[v] = n_edges;
    end
    e_to[n_edges] = t;
    e_w[n_edges] = w;
    n_edges++;
    last_src = f;
  endfunction

  function automatic bit still_relaxable(int unsigned u, int unsigned nv);
    longint du, w;
    int unsigned hi, v;
    du = dist_m[u];
    if (du == DIST_INF) return 0;
    hi = row_hi(u);
    for (int unsigned j = row_lo(u); j < hi && j < MAX_EDGES; j++) begin
      v = e_to[j];
      w = e_w[j];
      if (v >= nv) continue;
      if (du > longint'(DIST_INF) - w) continue;
      if (du + w < dist_m[v]) return 1;
    end
    return 0;
  endfunction

  function automatic int unsigned shortest_paths();
    int unsigned nv, passes, hi, v;
    bit improved, cyc;
    longint du, w, cand;
    nv = live_nv();
    passes = 0;
    improved = 1;
    cyc = 0;
    for (int unsigned u = 0; u < nv; u++) begin
      dist_m[u] = DIST_INF;
      pv[u] = 0;
      pidx[u] = '0;
      fnow[u] = 0;
      fnext[u] = 0;
    end
    if (cfg_src < nv) begin
      dist_m[cfg_src] = 0;
      fnow[cfg_src] = 1;
    end
    for (int unsigned iter = 0; iter + 1 < nv && improved; iter++) begin
      passes++;
      for (int u = 0; u < MAX_VERTICES; u++) fnext[u] = 0;
      improved = 0;
      for (int unsigned u = 0; u < nv; u++) begin
        if (!fnow[u] || dist_m[u] == DIST_INF) continue;
        du = dist_m[u];
        hi = row_hi(u);
        for (int unsigned j = row_lo(u); j < hi && j < MAX_EDGES; j++) begin
          v = e_to[j];
          w = e_w[j];
          if (v >= nv) continue;
          if (du > longint'(DIST_INF) - w) continue;
          cand = du + w;
          if (cand < -64'sd2147483648) continue;
          if (cand >= dist_m[v]) continue;
          dist_m[v] = int'(cand);
          pv[v] = 1;
          pidx[v] = u[VA_W-1:0];
          fnext[v] = 1;
          improved = 1;
        end
      end
      // last allowed pass still improved: look for edges left to relax
      if (improved && iter + 2 == nv) begin
        for (int unsigned u = 0; u < nv && !cyc; u++)
          if (fnext[u] && still_relaxable(u, nv)) cyc = 1;
        if (cyc) break;
      end
      if (!improved) break;
      for (int u = 0; u < MAX_VERTICES; u++) fnow[u] = fnext[u];
    end
    if (!cyc && passes + 1 == nv) begin
      for (int unsigned u = 0; u < nv && !cyc; u++)
        if (still_relaxable(u, nv)) cyc = 1;
    end
    neg_cyc = cyc;
    return passes;
  endfunction

  function automatic void predict_word(logic [1:0] k, logic [VA_W-1:0] f,
                                       logic [VA_W-1:0] t,
                                       logic signed [WEIGHT_BITS-1:0] w,
                                       logic [VA_W-1:0] rv);
    answer_t a;
    int unsigned p;
    a = '{rk: 0, nc: 0, passes: '0, ed: 0, vtx: '0, span: '0, reach: 0, hp: 0,
          pred: '0};
    case (k)
      KIND_LOAD: begin
        store_edge(f, t, int'(w));
      end
      KIND_RUN: begin
        p = shortest_paths();
        a.nc = neg_cyc;
        a.passes = p[9:0];
        a.ed = dropped;
        answer_q.push_back(a);
      end
      KIND_READ: begin
        a.rk = 1;
        a.nc = neg_cyc;
        a.ed = dropped;
        a.vtx = rv;
        a.span = DIST_INF;
        if (rv < live_nv()) begin
          a.span = dist_m[rv];
          a.hp = pv[rv];
          a.pred = pv[rv] ? pidx[rv] : '0;
        end
        a.reach = (a.span != DIST_INF);
        answer_q.push_back(a);
      end
      default: ;
    endcase
  endfunction

  task automatic chk(input string nm, input longint e, input longint a);
    if (e != a) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, e, a);
      fails++;
    end
  endtask

  // ---------------- driver, monitor, receiver ----------------
  always @(negedge clk) begin
    word_t w;
    if (!rst && (taken || !in_valid)) begin
      taken = 0;
      if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = word_q.pop_front();
        in_valid <= 1'b1;
        kind <= w.kd;
        from_vertex <= w.src;
        to_vertex <= w.dst;
        weight <= w.wt;
        read_vertex <= w.rd;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    answer_t a;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_word(kind, from_vertex, to_vertex, weight, read_vertex);
        taken = 1;
      end
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected word: kind %0d distance %0d", $time,
                   result_kind, distance);
          fails++;
        end else begin
          a = answer_q.pop_front();
          chk("result_kind", a.rk, result_kind);
          chk("negative_cycle", a.nc, negative_cycle);
          chk("passes_done", a.passes, passes_done);
          chk("edges_dropped", a.ed, edges_dropped);
          chk("vertex", a.vtx, vertex);
          chk("distance", a.span, distance);
          chk("reachable", a.reach, reachable);
          chk("has_predecessor", a.hp, has_predecessor);
          chk("predecessor", a.pred, predecessor);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  int unsigned gen_cnt = 0;
  int unsigned gen_last = 0;
  int unsigned written_max = 0;
  int          items = 0;

  task automatic reg_write(input logic idx, input int unsigned val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_VERTEX_COUNT) cfg_nv = val[10:0];
    else cfg_src = val[9:0];
  endtask

  task automatic set_graph(input int unsigned nv, input int unsigned s);
    reg_write(REG_VERTEX_COUNT, nv);
    reg_write(REG_SOURCE_VERTEX, s);
  endtask

  task automatic settle();
    while (word_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void gen_load(int unsigned f, int unsigned t, int w);
    word_q.push_back('{kd: KIND_LOAD, src: f[9:0], dst: t[9:0], wt: w[15:0], rd: '0});
    if (!(gen_cnt >= MAX_EDGES || (gen_cnt > 0 && f < gen_last))) begin
      gen_cnt++;
      gen_last = f;
    end
    items++;
  endfunction

  function automatic void gen_run();
    word_q.push_back('{kd: KIND_RUN, src: 10'($urandom), dst: 10'($urandom),
                       wt: 16'($urandom), rd: 10'($urandom)});
    if (live_nv() > written_max) written_max = live_nv();
    items++;
  endfunction

  function automatic void gen_read(int unsigned v);
    word_q.push_back('{kd: KIND_READ, src: '0, dst: '0, wt: '0, rd: v[9:0]});
    items++;
  endfunction

  // reads only touch vertices some run has written, or ones outside the graph
  function automatic void gen_any_read();
    int unsigned eff, lim;
    eff = live_nv();
    lim = (eff < written_max) ? eff : written_max;
    if (eff < MAX_VERTICES && (lim == 0 || $urandom_range(4) == 0))
      gen_read($urandom_range(1023, eff));
    else
      gen_read($urandom_range(lim - 1));
  endfunction

  function automatic int rand_weight();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(2000);
    if (r < 80) return -int'($urandom_range(400, 1));
    return int'(16'sh0 + $signed(16'($urandom)));
  endfunction

  initial begin
    int unsigned nv, s, n, extra;
    int p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: small graph with a negative edge, then a negative cycle
    set_graph(3, 0);
    gen_load(0, 1, 5);
    gen_load(0, 1023, 7);
    gen_load(1, 2, -3);
    gen_load(2, 0, 32767);
    gen_load(2, 3, -32768);
    gen_load(3, 4, -10);
    gen_load(4, 3, 2);
    gen_run();
    gen_read(0); gen_read(1); gen_read(2); gen_read(500);
    settle();
    set_graph(5, 0);
    gen_run();
    gen_read(3); gen_read(4);
    // out of order source is dropped
    gen_load(2, 1, 1);
    word_q.push_back('{kd: 2'd3, src: '1, dst: '1, wt: '1, rd: '1});
    gen_run();
    settle();
    set_graph(1, 0);
    gen_run();
    gen_read(0); gen_read(1023);
    settle();
    set_graph(0, 0);
    gen_run();
    settle();
    set_graph(2047, 1000);
    gen_run();
    gen_read(1000); gen_read(5);
    settle();
    set_graph(5, 7);   // source outside the graph
    gen_run();
    gen_read(2);
    settle();

    // long chain whose tail candidates exceed infinity
    for (int unsigned v = 5; v < 36; v++) gen_load(v, v + 1, 32767);
    settle();
    set_graph(37, 5);
    gen_run();
    gen_read(36); gen_read(35); gen_read(34);
    settle();

    p = 0;
    while (items < 1150) begin
      case (p % 5)
        1: begin idle_pct = 83; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 83; end
        3: begin idle_pct = 14; stall_pct = 14; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      n = $urandom_range(19);
      if (n == 0) begin
        nv = $urandom_range(1) ? 1024 : 2047;
        s = $urandom_range(1022, 900);
      end else begin
        nv = (n == 1) ? $urandom_range(4, 1) : $urandom_range(64, 2);
        s = ($urandom_range(99) < 85) ? $urandom_range(nv - 1) : $urandom_range(1023);
      end
      set_graph(nv, s);
      if (p == 1) begin
        // long output hold while reads keep coming: input must back up
        hold_cnt = 500;
        for (int i = 0; i < 40; i++) gen_any_read();
      end
      n = $urandom_range(25);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0 && gen_last > 0)
          s = $urandom_range(gen_last - 1);
        else begin
          s = gen_last + ($urandom_range(9) == 0);
          if (s < 37) s = 37;
          if (s > 120) s = 120;
        end
        gen_load(s, ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(63),
                 rand_weight());
        if ($urandom_range(15) == 0)
          word_q.push_back('{kd: 2'd3, src: 10'($urandom), dst: 10'($urandom),
                             wt: 16'($urandom), rd: 10'($urandom)});
      end
      if (written_max > 0 && $urandom_range(3) == 0) gen_any_read();
      if ($urandom_range(9) != 0) gen_run();
      extra = $urandom_range(12, 3);
      for (int unsigned i = 0; i < extra; i++) gen_any_read();
      settle();
      p++;
    end

    // a few edges from the top vertex fill a long stretch of row starts
    idle_pct = 0;
    stall_pct = 0;
    extra = 5;
    for (int unsigned i = 0; i < extra; i++)
      gen_load(1023, $urandom_range(1023), int'($signed(16'($urandom))));
    settle();
    set_graph(40, 37);
    gen_run();
    gen_read(37); gen_read(39); gen_read(1023);
    for (int i = 0; i < 5; i++) gen_any_read();
    settle();

    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fbf_pkg.sv
sv/fbf_ctrl.sv
sv/fbf_dpath.sv
sv/frontier_bellman_ford_top.sv
sim/frontier_bellman_ford_top_test.sv
